### sv/ftr_pkg.sv
`default_nettype none

package ftr_pkg;

   // received size counter width and its saturation value
   localparam int SIZE_WIDTH = 32;
   localparam logic [SIZE_WIDTH-1:0] SIZE_MAX = '1;
   // width that holds a segment end and any size for compares
   localparam int CMP_WIDTH = (SIZE_WIDTH > 33) ? SIZE_WIDTH : 33;

   // event codes; the remaining codes are unsupported events
   typedef enum logic [3:0] {
      CMD_ENTER       = 4'd0,
      CMD_ABANDON     = 4'd1,
      CMD_CANCEL_NOTE = 4'd2,
      CMD_METADATA    = 4'd3,
      CMD_FILEDATA    = 4'd4,
      CMD_EOF_OK      = 4'd5,
      CMD_EOF_CANCEL  = 4'd6,
      CMD_TIMEOUT     = 4'd7,
      CMD_CANCEL_REQ  = 4'd8,
      CMD_REPORT      = 4'd9
   } cmd_type;

   // receiver states
   typedef enum logic [1:0] {
      ST_WAIT_MD  = 2'd0,
      ST_WAIT_EOF = 2'd1,
      ST_DONE     = 2'd2
   } state_type;

   // fault codes
   typedef enum logic [1:0] {
      FAULT_NONE       = 2'd0,
      FAULT_INACTIVITY = 2'd1,
      FAULT_SIZE       = 2'd2,
      FAULT_CHECKSUM   = 2'd3
   } fault_type;

   // condition codes
   localparam logic [3:0] CC_NO_ERROR   = 4'd0;
   localparam logic [3:0] CC_CANCEL_REQ = 4'd15;

   // request transaction
   typedef struct packed {
      logic [3:0]  command;
      logic [31:0] data_offset;
      logic [15:0] segment_length;
      logic [31:0] eof_file_size;
      logic [31:0] eof_checksum;
      logic [3:0]  eof_condition;
      logic [31:0] stored_checksum;
      logic        transfer_active;
      logic        store_ok;
      logic        messages_ok;
      logic        delete_ok;
   } req_type;

   // response transaction
   typedef struct packed {
      logic        ind_abandoned;
      logic        ind_finished;
      logic        ind_metadata;
      logic        ind_segment;
      logic        ind_eof;
      logic        ind_report;
      logic [1:0]  fault_kind;
      logic        issue_cancel;
      logic        unsupported;
      logic [1:0]  state_now;
      logic [3:0]  condition_now;
      logic [31:0] size_now;
   } rsp_type;

endpackage

`default_nettype wire

### sv/ftr_core.sv
`default_nettype none

module ftr_core (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            step_en,
   input  wire ftr_pkg::req_type item,
   output ftr_pkg::rsp_type     result
);
   import ftr_pkg::*;

   state_type             state_ff, state_in;
   logic [SIZE_WIDTH-1:0] size_ff, size_in;
   logic [3:0]            cond_ff, cond_in;

   logic                  active;
   logic [CMP_WIDTH-1:0]  size_ext;
   logic [CMP_WIDTH-1:0]  seg_end;
   logic [CMP_WIDTH-1:0]  seg_sat;
   logic                  size_err;
   logic                  sum_err;

   // shared compares
   assign active   = (state_ff inside {ST_WAIT_MD, ST_WAIT_EOF});
   assign size_ext = CMP_WIDTH'(size_ff);
   assign seg_end  = CMP_WIDTH'(item.data_offset) + CMP_WIDTH'(item.segment_length);
   assign seg_sat  = (seg_end > CMP_WIDTH'(SIZE_MAX)) ? CMP_WIDTH'(SIZE_MAX) : seg_end;
   assign size_err = item.transfer_active && (size_ext > CMP_WIDTH'(item.eof_file_size));
   assign sum_err  = item.transfer_active && (item.stored_checksum != item.eof_checksum);

   // next state
   always_comb begin
      state_in = state_ff;
      size_in  = size_ff;
      cond_in  = cond_ff;
      if (active) begin
         case (item.command)
            CMD_ENTER: begin
               if (state_ff == ST_WAIT_MD) begin
                  cond_in = CC_NO_ERROR;
                  size_in = '0;
               end
            end
            CMD_ABANDON, CMD_CANCEL_NOTE: begin
               state_in = ST_DONE;
            end
            CMD_METADATA: begin
               if (state_ff == ST_WAIT_MD) begin
                  state_in = item.messages_ok ? ST_WAIT_EOF : ST_DONE;
               end
            end
            CMD_FILEDATA: begin
               if (state_ff == ST_WAIT_EOF && item.transfer_active) begin
                  if (!item.store_ok) begin
                     state_in = ST_DONE;
                  end else if (size_ext < seg_sat) begin
                     size_in = seg_sat[SIZE_WIDTH-1:0];
                  end
               end
            end
            CMD_EOF_OK: begin
               if (state_ff == ST_WAIT_MD) begin
                  state_in = ST_DONE;
               end else if (size_err) begin
                  state_in = state_ff;
               end else if (sum_err) begin
                  if (!item.delete_ok) begin
                     state_in = ST_DONE;
                  end
               end else begin
                  state_in = ST_DONE;
               end
            end
            CMD_EOF_CANCEL: begin
               cond_in  = item.eof_condition;
               state_in = ST_DONE;
            end
            CMD_CANCEL_REQ: begin
               cond_in = CC_CANCEL_REQ;
            end
            default: begin
               state_in = state_ff;
            end
         endcase
      end
   end

   // result flags
   always_comb begin
      result               = '0;
      result.fault_kind    = FAULT_NONE;
      if (active) begin
         case (item.command)
            CMD_ENTER: begin
               result.unsupported = (state_ff != ST_WAIT_MD);
            end
            CMD_ABANDON: begin
               result.ind_abandoned = 1'b1;
            end
            CMD_CANCEL_NOTE, CMD_EOF_CANCEL: begin
               result.ind_finished = 1'b1;
            end
            CMD_METADATA: begin
               result.ind_metadata = (state_ff == ST_WAIT_MD);
               result.unsupported  = (state_ff != ST_WAIT_MD);
            end
            CMD_FILEDATA: begin
               result.ind_segment = (state_ff == ST_WAIT_EOF);
               result.unsupported = (state_ff != ST_WAIT_EOF);
            end
            CMD_EOF_OK: begin
               if (state_ff == ST_WAIT_MD) begin
                  result.ind_finished = 1'b1;
               end else begin
                  result.ind_eof = 1'b1;
                  if (size_err) begin
                     result.fault_kind = FAULT_SIZE;
                  end else if (sum_err) begin
                     result.fault_kind = FAULT_CHECKSUM;
                  end else begin
                     result.ind_finished = 1'b1;
                  end
               end
            end
            CMD_TIMEOUT: begin
               result.fault_kind = FAULT_INACTIVITY;
            end
            CMD_CANCEL_REQ: begin
               result.issue_cancel = 1'b1;
            end
            CMD_REPORT: begin
               result.ind_report = 1'b1;
            end
            default: begin
               result.unsupported = 1'b1;
            end
         endcase
      end
      // status after the step
      result.state_now     = state_in;
      result.condition_now = cond_in;
      result.size_now      = 32'(size_in);
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_WAIT_MD;
         size_ff  <= '0;
         cond_ff  <= CC_NO_ERROR;
      end else if (step_en) begin
         state_ff <= state_in;
         size_ff  <= size_in;
         cond_ff  <= cond_in;
      end
   end

endmodule

`default_nettype wire

### sv/file_transfer_receiver_fsm.sv
// an accepted transaction is held in the input register, and its response is registered
// when the response register is free or drains; rsp_valid rises once it holds the response
// throughput: one transaction per cycle unless the response stalls; set by the state loop
// req_ready follows rsp_ready and falls once both registers hold a stalled transaction
// reset (synchronous, active high): wait-metadata state, size and condition code zero,
// both pipeline registers empty
`default_nettype none

module file_transfer_receiver_fsm (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire ftr_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output ftr_pkg::rsp_type      rsp_data
);
   import ftr_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   logic    advance;
   rsp_type step_result;

   // move a transaction from input register to response register
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   // receiver state and step logic
   ftr_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_data_ff),
      .result  (step_result)
   );

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= step_result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire

### sv/ftr_checker.sv
`default_nettype none

module ftr_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire ftr_pkg::rsp_type rsp_data
);
   import ftr_pkg::*;

   // no response right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // unsupported events raise nothing
   a_unsup_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.unsupported |->
         !rsp_data.ind_abandoned && !rsp_data.ind_finished && !rsp_data.ind_metadata &&
         !rsp_data.ind_segment && !rsp_data.ind_eof && !rsp_data.ind_report &&
         !rsp_data.issue_cancel && rsp_data.fault_kind == FAULT_NONE)
      else $error("unsupported event raised an indication");

   // a finished transfer ends in completed state
   a_finish_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.ind_finished || rsp_data.ind_abandoned) |->
         rsp_data.state_now == ST_DONE)
      else $error("finished without completing");

   // segment indication never leaves machine waiting for metadata
   a_seg_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.ind_segment |-> rsp_data.state_now != ST_WAIT_MD)
      else $error("segment indication in wait-metadata state");

endmodule

bind file_transfer_receiver_fsm ftr_checker u_ftr_checker (.*);

`default_nettype wire
